// ===== src/apc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package apc_pkg;

  localparam int DATA_W    = 32;
  localparam int WIDE_W    = 52;
  localparam int SUM_W     = 40;
  localparam int PADDR_W   = 4;

  localparam logic [1:0] REG_NODE_COUNT      = 2'd0;
  localparam logic [1:0] REG_ITERATION_COUNT = 2'd1;
  localparam logic [1:0] REG_DAMPING         = 2'd2;
  localparam logic [1:0] REG_PREFERENCE      = 2'd3;

  localparam logic signed [DATA_W-1:0] S32_MIN = {1'b1, {(DATA_W-1){1'b0}}};
  localparam logic signed [DATA_W-1:0] S32_MAX = {1'b0, {(DATA_W-1){1'b1}}};

  typedef struct packed {
    logic [6:0]               node_count;
    logic [9:0]               iteration_count;
    logic [15:0]              damping;
    logic signed [DATA_W-1:0] preference;
    logic                     node_count_wr;
  } cfg_t;

  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [WIDE_W-1:0] v);
    logic [WIDE_W-DATA_W:0] hi;
    hi = v[WIDE_W-1:DATA_W-1];
    if ((&hi) || !(|hi)) begin
      return v[DATA_W-1:0];
    end
    return v[WIDE_W-1] ? S32_MIN : S32_MAX;
  endfunction

endpackage
`default_nettype wire

// ===== src/affinity_propagation_cluster_top.sv =====
// Load: one similarity request per cycle while in_stall is low; the request marked last
// starts the run. Run: a diagonal pass, then row and column passes per iteration (none if
// iteration_count is 0), paced by the single read port of each RAM and the damping pipeline
// drain. Then an exemplar pass and, per node, an exemplar result or an assignment pass;
// input reopens after the last. A node_count write stalls input while the load position is
// recomputed. Synchronous reset restores register defaults; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none
module affinity_propagation_cluster_top #(
  parameter int MAX_NODES = 64
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [apc_pkg::PADDR_W-1:0] paddr,
  input  wire logic [31:0]                 pwdata,
  output logic      [31:0]                 prdata,
  output logic                             pready,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic signed [31:0]          similarity,
  input  wire logic                        last_entry,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [5:0]                       node_index,
  output logic [5:0]                       exemplar_index,
  output logic                             is_exemplar,
  output logic                             last_node
);

  localparam int IW  = $clog2(MAX_NODES);
  localparam int NW  = $clog2(MAX_NODES + 1);
  localparam int AW  = 2 * IW;
  localparam int D   = MAX_NODES * MAX_NODES;
  localparam int RD  = 1 << AW;
  localparam int PW  = $clog2(D + 1);
  localparam int DCW = (PW > 1) ? $clog2(PW) : 1;

  typedef enum logic [3:0] {
    ST_LOAD, ST_DIAG, ST_ROWMAX, ST_ROWRESP, ST_COLSUM, ST_COLAVAIL,
    ST_EXEM, ST_ASSIGN, ST_EMIT
  } state_t;

  apc_pkg::cfg_t cfg;
  state_t        state;

  logic [NW-1:0] n_eff;
  logic [IW-1:0] nm1;
  logic [PW-1:0] nn;
  logic [PW-1:0] ptr;
  logic [IW-1:0] row;
  logic [IW-1:0] col;

  logic           div_busy;
  logic           div_done;
  logic [DCW-1:0] div_cnt;
  logic [NW-1:0]  rem;
  logic [PW-1:0]  quo;
  logic [NW:0]    rem_sh;

  logic [IW-1:0] ci;
  logic [IW-1:0] cj;
  logic          idone;
  logic [9:0]    it;
  logic          first;
  logic          rd_v;
  logic [IW-1:0] rd_j;

  logic signed [31:0] v1, v2;
  logic [IW-1:0]      p1;
  logic signed [apc_pkg::SUM_W-1:0] sum;

  logic               st_v;
  logic signed [31:0] st_nv, st_ov;
  logic [AW-1:0]      st_addr;

  logic               d_v;
  logic signed [31:0] d_data;
  logic [AW-1:0]      d_addr;
  logic               d_busy;

  logic [MAX_NODES-1:0] ex;
  logic [MAX_NODES-1:0] ex_eff;
  logic                 any;
  logic                 found;
  logic signed [31:0]   bv;
  logic [IW-1:0]        bi;

  logic          s_we, r_we, a_we;
  logic [AW-1:0] s_waddr, s_raddr, r_raddr, a_raddr;
  logic [31:0]   s_wdata, s_rdata, r_rdata, a_rdata;

  logic          accept;
  logic          pass, issue, pass_end, pipe_busy;
  logic [IW-1:0] tgt;
  logic          tgt_ex;

  logic signed [31:0] sv, av, rv, sa, cv1, cv2, nv1, nv2, m, rn, term, an_sat, dsum_r;
  logic [IW-1:0]      np1;
  logic signed [40:0] an;
  logic signed [32:0] diag_sum;

  apc_cfg u_cfg (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
  );

  apc_ram #(.W(32), .D(RD)) u_sim (
    .clk, .we(s_we), .waddr(s_waddr), .wdata(s_wdata), .raddr(s_raddr), .rdata(s_rdata)
  );
  apc_ram #(.W(32), .D(RD)) u_resp (
    .clk, .we(r_we), .waddr(d_addr), .wdata(d_data), .raddr(r_raddr), .rdata(r_rdata)
  );
  apc_ram #(.W(32), .D(RD)) u_avail (
    .clk, .we(a_we), .waddr(d_addr), .wdata(d_data), .raddr(a_raddr), .rdata(a_rdata)
  );

  apc_damp #(.AW(AW)) u_damp (
    .clk, .rst, .in_v(st_v), .nv(st_nv), .ov(st_ov), .in_addr(st_addr),
    .damping(cfg.damping), .out_v(d_v), .out_data(d_data), .out_addr(d_addr),
    .busy(d_busy)
  );

  always_comb begin
    int nc;
    nc = int'(cfg.node_count);
    if (nc < 2) begin
      n_eff = NW'(2);
    end else if (nc > MAX_NODES) begin
      n_eff = NW'(MAX_NODES);
    end else begin
      n_eff = NW'(nc);
    end
  end
  assign nm1 = IW'(n_eff - NW'(1));

  assign in_stall = (state != ST_LOAD) || div_busy || div_done;
  assign accept   = in_valid && !in_stall;
  assign rem_sh   = {rem, ptr[div_cnt]};

  assign pass = (state == ST_ROWMAX) || (state == ST_ROWRESP) || (state == ST_COLSUM) ||
                (state == ST_COLAVAIL) || (state == ST_EXEM) || (state == ST_ASSIGN);
  assign pipe_busy = rd_v || st_v || d_busy;
  assign issue     = pass && !idone;
  assign pass_end  = pass && idone && !pipe_busy;

  assign s_we    = (accept && (ptr < nn)) || (state == ST_DIAG);
  assign s_waddr = (state == ST_DIAG) ? {ci, ci} : {row, col};
  assign s_wdata = (state == ST_DIAG) ? cfg.preference : similarity;
  assign s_raddr = {ci, cj};
  assign r_raddr = ((state == ST_COLSUM) || (state == ST_COLAVAIL)) ? {cj, ci} :
                   (state == ST_EXEM) ? {cj, cj} : {ci, cj};
  assign a_raddr = (state == ST_COLAVAIL) ? {cj, ci} :
                   (state == ST_EXEM) ? {cj, cj} : {ci, cj};
  assign r_we = d_v && (state == ST_ROWRESP);
  assign a_we = d_v && (state == ST_COLAVAIL);

  assign ex_eff = any ? ex : (ex | MAX_NODES'(1));
  assign tgt    = (state == ST_EMIT) ? IW'(ci + IW'(1)) : '0;
  assign tgt_ex = ex_eff[tgt];

  always_comb begin
    sv  = s_rdata;
    rv  = r_rdata;
    av  = first ? 32'sd0 : a_rdata;
    sa  = apc_pkg::sat32({{20{sv[31]}}, sv} + {{20{av[31]}}, av});
    cv1 = (rd_j == '0) ? apc_pkg::S32_MIN : v1;
    cv2 = (rd_j == '0) ? apc_pkg::S32_MIN : v2;
    nv1 = cv1;
    nv2 = cv2;
    np1 = (rd_j == '0) ? '0 : p1;
    if (sa > cv1) begin
      nv1 = sa;
      nv2 = cv1;
      np1 = rd_j;
    end else if (sa > cv2) begin
      nv2 = sa;
    end
    m  = (rd_j == p1) ? v2 : v1;
    rn = apc_pkg::sat32({{20{sv[31]}}, sv} - {{20{m[31]}}, m});
    term = ((rd_j == ci) || (rv > 0)) ? rv : 32'sd0;
    an = {sum[39], sum} - {{9{term[31]}}, term};
    if ((rd_j != ci) && (an > 0)) begin
      an = '0;
    end
    an_sat   = apc_pkg::sat32({{11{an[40]}}, an});
    dsum_r   = first ? 32'sd0 : rv;
    diag_sum = {dsum_r[31], dsum_r} + {av[31], av};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_LOAD;
      ptr       <= '0;
      row       <= '0;
      col       <= '0;
      div_busy  <= 1'b0;
      div_done  <= 1'b0;
      ci        <= '0;
      cj        <= '0;
      idone     <= 1'b0;
      it        <= '0;
      first     <= 1'b1;
      rd_v      <= 1'b0;
      st_v      <= 1'b0;
      out_valid <= 1'b0;
      any       <= 1'b0;
      ex        <= '0;
      found     <= 1'b0;
    end else begin
      rd_v <= issue;
      st_v <= rd_v && ((state == ST_ROWRESP) || (state == ST_COLAVAIL));

      if (cfg.node_count_wr) begin
        div_busy <= 1'b1;
        div_cnt  <= DCW'(PW - 1);
        rem      <= '0;
        quo      <= '0;
      end else if (div_busy) begin
        if (rem_sh >= {1'b0, n_eff}) begin
          rem          <= NW'(rem_sh - {1'b0, n_eff});
          quo[div_cnt] <= 1'b1;
        end else begin
          rem <= NW'(rem_sh);
        end
        if (div_cnt == '0) begin
          div_busy <= 1'b0;
          div_done <= 1'b1;
        end else begin
          div_cnt <= div_cnt - DCW'(1);
        end
      end else if (div_done) begin
        div_done <= 1'b0;
        row      <= IW'(quo);
        col      <= IW'(rem);
      end

      if (issue) begin
        if (cj == nm1) begin
          idone <= 1'b1;
        end else begin
          cj <= cj + IW'(1);
        end
      end
      if (pass_end) begin
        cj    <= '0;
        idone <= 1'b0;
      end

      case (state)
        ST_LOAD: begin
          if (accept) begin
            if (last_entry) begin
              ptr   <= '0;
              row   <= '0;
              col   <= '0;
              ci    <= '0;
              state <= ST_DIAG;
            end else if (ptr < nn) begin
              ptr <= ptr + PW'(1);
              if (col == nm1) begin
                col <= '0;
                row <= row + IW'(1);
              end else begin
                col <= col + IW'(1);
              end
            end
          end
        end
        ST_DIAG: begin
          ex    <= '0;
          any   <= 1'b0;
          first <= 1'b1;
          it    <= '0;
          if (ci == nm1) begin
            ci    <= '0;
            state <= (cfg.iteration_count == '0) ? ST_EXEM : ST_ROWMAX;
          end else begin
            ci <= ci + IW'(1);
          end
        end
        ST_ROWMAX: begin
          if (rd_v) begin
            v1 <= nv1;
            v2 <= nv2;
            p1 <= np1;
          end
          if (pass_end) begin
            state <= ST_ROWRESP;
          end
        end
        ST_ROWRESP: begin
          if (pass_end) begin
            if (ci == nm1) begin
              ci    <= '0;
              state <= ST_COLSUM;
            end else begin
              ci    <= ci + IW'(1);
              state <= ST_ROWMAX;
            end
          end
        end
        ST_COLSUM: begin
          if (rd_v) begin
            sum <= ((rd_j == '0) ? '0 : sum) + {{8{term[31]}}, term};
          end
          if (pass_end) begin
            state <= ST_COLAVAIL;
          end
        end
        ST_COLAVAIL: begin
          if (pass_end) begin
            if (ci == nm1) begin
              ci    <= '0;
              first <= 1'b0;
              if (it + 10'd1 == cfg.iteration_count) begin
                state <= ST_EXEM;
              end else begin
                it    <= it + 10'd1;
                state <= ST_ROWMAX;
              end
            end else begin
              ci    <= ci + IW'(1);
              state <= ST_COLSUM;
            end
          end
        end
        ST_EXEM: begin
          if (rd_v) begin
            ex[rd_j] <= diag_sum > 0;
            if (diag_sum > 0) begin
              any <= 1'b1;
            end
          end
          if (pass_end) begin
            ex <= ex_eff;
            ci <= tgt;
            if (tgt_ex) begin
              out_valid      <= 1'b1;
              node_index     <= 6'(tgt);
              exemplar_index <= 6'(tgt);
              is_exemplar    <= 1'b1;
              last_node      <= (tgt == nm1);
              state          <= ST_EMIT;
            end else begin
              found <= 1'b0;
              state <= ST_ASSIGN;
            end
          end
        end
        ST_ASSIGN: begin
          if (rd_v && ex_eff[rd_j] && (!found || (sv > bv))) begin
            bv    <= sv;
            bi    <= rd_j;
            found <= 1'b1;
          end
          if (pass_end) begin
            out_valid      <= 1'b1;
            node_index     <= 6'(ci);
            exemplar_index <= 6'(bi);
            is_exemplar    <= 1'b0;
            last_node      <= (ci == nm1);
            state          <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (out_valid && !out_stall) begin
            if (ci == nm1) begin
              out_valid <= 1'b0;
              ci        <= '0;
              state     <= ST_LOAD;
            end else begin
              ci <= tgt;
              if (tgt_ex) begin
                out_valid      <= 1'b1;
                node_index     <= 6'(tgt);
                exemplar_index <= 6'(tgt);
                is_exemplar    <= 1'b1;
                last_node      <= (tgt == nm1);
              end else begin
                out_valid <= 1'b0;
                found     <= 1'b0;
                state     <= ST_ASSIGN;
              end
            end
          end
        end
        default: state <= ST_LOAD;
      endcase
    end

    nn   <= PW'(n_eff) * PW'(n_eff);
    rd_j <= cj;
    if (state == ST_ROWRESP) begin
      st_nv   <= rn;
      st_ov   <= first ? 32'sd0 : r_rdata;
      st_addr <= {ci, rd_j};
    end else begin
      st_nv   <= an_sat;
      st_ov   <= av;
      st_addr <= {rd_j, ci};
    end
  end

  assert property (@(posedge clk) disable iff (rst) out_valid |-> state == ST_EMIT)
    else $error("result shown outside emit");
  assert property (@(posedge clk) disable iff (rst) r_we |-> state == ST_ROWRESP)
    else $error("responsibility written outside its pass");
  assert property (@(posedge clk) disable iff (rst) state != ST_LOAD |-> in_stall)
    else $error("input open while busy");
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && last_node |=> state == ST_LOAD)
    else $error("run did not end after last node");
  assert property (@(posedge clk) disable iff (rst)
    accept && last_entry |=> state == ST_DIAG && ptr == '0)
    else $error("last request did not start the run");

endmodule
`default_nettype wire

// ===== src/apc_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
module apc_ram #(
  parameter int W = 32,
  parameter int D = 4096
) (
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire logic [$clog2(D)-1:0] waddr,
  input  wire logic [W-1:0]         wdata,
  input  wire logic [$clog2(D)-1:0] raddr,
  output logic      [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== src/apc_damp.sv =====
`timescale 1ns / 1ps
`default_nettype none
module apc_damp #(
  parameter int AW = 12
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     in_v,
  input  wire logic signed [31:0]       nv,
  input  wire logic signed [31:0]       ov,
  input  wire logic [AW-1:0]            in_addr,
  input  wire logic [15:0]              damping,
  output logic                          out_v,
  output logic signed [31:0]            out_data,
  output logic [AW-1:0]                 out_addr,
  output logic                          busy
);

  logic [16:0]        wn;
  logic signed [49:0] p_new;
  logic signed [49:0] p_old;
  logic               p_v;
  logic [AW-1:0]      p_addr;
  logic signed [51:0] t;
  logic signed [51:0] q;

  assign wn = 17'(18'h10000 - {2'b00, damping});
  assign t  = {{2{p_new[49]}}, p_new} + {{2{p_old[49]}}, p_old} + 52'sd32768;
  assign q  = t >>> 16;
  assign busy = p_v | out_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_v   <= 1'b0;
      out_v <= 1'b0;
    end else begin
      p_v   <= in_v;
      out_v <= p_v;
    end
    p_new    <= $signed({1'b0, wn}) * nv;
    p_old    <= $signed({1'b0, damping}) * ov;
    p_addr   <= in_addr;
    out_data <= apc_pkg::sat32(q);
    out_addr <= p_addr;
  end

  assert property (@(posedge clk) disable iff (rst) in_v |=> p_v)
    else $error("damp stage one lost a request");
  assert property (@(posedge clk) disable iff (rst) p_v |=> out_v && out_addr == $past(p_addr))
    else $error("damp output address mismatch");
  assert property (@(posedge clk) disable iff (rst) out_v |-> $past(in_v, 2))
    else $error("damp output without request");

endmodule
`default_nettype wire

// ===== src/apc_cfg.sv =====
`timescale 1ns / 1ps
`default_nettype none
module apc_cfg (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [apc_pkg::PADDR_W-1:0]   paddr,
  input  wire logic [31:0]                   pwdata,
  output logic      [31:0]                   prdata,
  output logic                               pready,
  output apc_pkg::cfg_t                      cfg
);

  logic [6:0]         node_count;
  logic [9:0]         iteration_count;
  logic [15:0]        damping;
  logic signed [31:0] preference;
  logic               wr;
  logic [1:0]         idx;

  assign pready = 1'b1;
  assign idx    = paddr[3:2];
  assign wr     = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      node_count      <= 7'd64;
      iteration_count <= 10'd100;
      damping         <= 16'd32768;
      preference      <= '0;
    end else if (wr) begin
      case (idx)
        apc_pkg::REG_NODE_COUNT:      node_count      <= pwdata[6:0];
        apc_pkg::REG_ITERATION_COUNT: iteration_count <= pwdata[9:0];
        apc_pkg::REG_DAMPING:         damping         <= pwdata[15:0];
        apc_pkg::REG_PREFERENCE:      preference      <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      apc_pkg::REG_NODE_COUNT:      prdata = {25'd0, node_count};
      apc_pkg::REG_ITERATION_COUNT: prdata = {22'd0, iteration_count};
      apc_pkg::REG_DAMPING:         prdata = {16'd0, damping};
      apc_pkg::REG_PREFERENCE:      prdata = preference;
      default:                      prdata = '0;
    endcase
  end

  assign cfg.node_count      = node_count;
  assign cfg.iteration_count = iteration_count;
  assign cfg.damping         = damping;
  assign cfg.preference      = preference;
  assign cfg.node_count_wr   = wr && (idx == apc_pkg::REG_NODE_COUNT);

endmodule
`default_nettype wire

// ===== dv/affinity_propagation_cluster_top_tb.sv =====
`timescale 1ns / 1ps
`default_nettype none
module affinity_propagation_cluster_top_tb;

  typedef struct {
    logic signed [31:0] sim;
    logic               last;
  } entry_t;

  typedef struct {
    logic [5:0] node;
    logic [5:0] exemplar;
    logic       is_ex;
    logic       last;
  } assign_t;

  localparam int MAXN = 64;
  localparam int STALL_LIMIT = 500000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [apc_pkg::PADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [31:0] similarity = '0;
  logic last_entry = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [5:0] node_index, exemplar_index;
  logic is_exemplar, last_node;

  entry_t  pending_entries[$];
  assign_t expected_assignments[$];

  logic [6:0]         cfg_nodes = 7'd64;
  logic [9:0]         cfg_iters = 10'd100;
  logic [15:0]        cfg_damp = 16'd32768;
  logic signed [31:0] cfg_pref = '0;

  int sim_mem[MAXN*MAXN];
  int resp_mem[MAXN*MAXN];
  int avail_mem[MAXN*MAXN];
  longint col_sum[MAXN];
  int load_ptr = 0;

  bit gen_written[MAXN*MAXN];
  int gen_ptr = 0;

  int errors = 0;
  int cyc = 0;
  int idle_cycles = 0;
  int entries_taken = 0;
  int results_seen = 0;
  int runs_done = 0;
  bit hold_done = 1'b0;
  int hold_cnt = 0;
  bit quiet;

  affinity_propagation_cluster_top i_dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_stall(in_stall),
    .similarity(similarity), .last_entry(last_entry),
    .out_valid(out_valid), .out_stall(out_stall),
    .node_index(node_index), .exemplar_index(exemplar_index),
    .is_exemplar(is_exemplar), .last_node(last_node)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  assign quiet = (cyc >= 30000) && (cyc < 45000);

  function automatic int active_count(logic [6:0] n);
    if (n < 2) return 2;
    if (n > MAXN) return MAXN;
    return n;
  endfunction

  function automatic int sat32v(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return int'(v);
  endfunction

  function automatic int damped(int nv, int ov);
    longint t;
    t = longint'(65536 - int'(cfg_damp)) * nv + longint'(cfg_damp) * ov + 32768;
    return sat32v(t >>> 16);
  endfunction

  task automatic pass_messages(int n);
    int p1, p2, v1, v2, a, m, rn, r;
    longint rp, an;
    for (int i = 0; i < n; i++) begin
      p1 = 0;
      v1 = sat32v(longint'(sim_mem[i*MAXN]) + avail_mem[i*MAXN]);
      for (int j = 1; j < n; j++) begin
        a = sat32v(longint'(sim_mem[i*MAXN+j]) + avail_mem[i*MAXN+j]);
        if (a > v1) begin
          v1 = a;
          p1 = j;
        end
      end
      p2 = (p1 == 0) ? 1 : 0;
      v2 = sat32v(longint'(sim_mem[i*MAXN+p2]) + avail_mem[i*MAXN+p2]);
      for (int j = 0; j < n; j++) begin
        if (j != p1) begin
          a = sat32v(longint'(sim_mem[i*MAXN+j]) + avail_mem[i*MAXN+j]);
          if (a > v2) begin
            v2 = a;
            p2 = j;
          end
        end
      end
      for (int j = 0; j < n; j++) begin
        m = (j == p1) ? v2 : v1;
        rn = sat32v(longint'(sim_mem[i*MAXN+j]) - m);
        resp_mem[i*MAXN+j] = damped(rn, resp_mem[i*MAXN+j]);
      end
    end
    for (int i = 0; i < n; i++) begin
      col_sum[i] = 0;
      for (int j = 0; j < n; j++) begin
        r = resp_mem[j*MAXN+i];
        if (j == i || r > 0) col_sum[i] += r;
      end
    end
    for (int j = 0; j < n; j++) begin
      for (int i = 0; i < n; i++) begin
        r = resp_mem[j*MAXN+i];
        rp = (j == i || r > 0) ? r : 0;
        an = col_sum[i] - rp;
        if (j != i && an > 0) an = 0;
        avail_mem[j*MAXN+i] = damped(sat32v(an), avail_mem[j*MAXN+i]);
      end
    end
  endtask

  task automatic cluster_entry(entry_t e);
    int n, best, bv, s;
    bit ex[MAXN];
    bit any, found;
    assign_t res;
    n = active_count(cfg_nodes);
    if (load_ptr < n*n) begin
      sim_mem[(load_ptr / n)*MAXN + load_ptr % n] = e.sim;
      load_ptr++;
    end
    if (e.last) begin
      load_ptr = 0;
      for (int i = 0; i < n; i++) sim_mem[i*MAXN+i] = cfg_pref;
      for (int k = 0; k < MAXN*MAXN; k++) begin
        resp_mem[k] = 0;
        avail_mem[k] = 0;
      end
      for (int it = 0; it < cfg_iters; it++) pass_messages(n);
      any = 1'b0;
      for (int i = 0; i < n; i++) begin
        ex[i] = (longint'(resp_mem[i*MAXN+i]) + avail_mem[i*MAXN+i]) > 0;
        if (ex[i]) any = 1'b1;
      end
      if (!any) ex[0] = 1'b1;
      for (int i = 0; i < n; i++) begin
        best = 0;
        if (ex[i]) begin
          best = i;
        end else begin
          found = 1'b0;
          bv = 0;
          for (int j = 0; j < n; j++) begin
            if (ex[j]) begin
              s = sim_mem[i*MAXN+j];
              if (!found || s > bv) begin
                bv = s;
                best = j;
                found = 1'b1;
              end
            end
          end
        end
        res.node = i[5:0];
        res.exemplar = best[5:0];
        res.is_ex = ex[i];
        res.last = (i == n-1);
        expected_assignments = {expected_assignments, res};
      end
      runs_done++;
    end
  endtask

  // driver
  always @(posedge clk) begin
    entry_t e;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (pending_entries.size() > 0 && (quiet || $urandom_range(99) >= 37)) begin
        e = pending_entries.pop_front();
        similarity <= e.sim;
        last_entry <= e.last;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // request acceptance and prediction
  always @(posedge clk) begin
    entry_t e;
    if (!rst && in_valid && !in_stall) begin
      e.sim = similarity;
      e.last = last_entry;
      cluster_entry(e);
      entries_taken++;
    end
  end

  // monitor
  always @(posedge clk) begin
    assign_t x;
    cyc <= cyc + 1;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (expected_assignments.size() == 0) begin
          $display("%0t: unexpected result node %0d exemplar %0d", $time,
                   node_index, exemplar_index);
          errors++;
        end else begin
          x = expected_assignments.pop_front();
          if (node_index !== x.node) begin
            $display("%0t: node_index expected %0d actual %0d", $time, x.node, node_index);
            errors++;
          end
          if (exemplar_index !== x.exemplar) begin
            $display("%0t: exemplar_index expected %0d actual %0d", $time,
                     x.exemplar, exemplar_index);
            errors++;
          end
          if (is_exemplar !== x.is_ex) begin
            $display("%0t: is_exemplar expected %0d actual %0d", $time, x.is_ex, is_exemplar);
            errors++;
          end
          if (last_node !== x.last) begin
            $display("%0t: last_node expected %0d actual %0d", $time, x.last, last_node);
            errors++;
          end
        end
      end
      if (!hold_done && results_seen >= 40 && out_valid) begin
        hold_done <= 1'b1;
        hold_cnt <= 3000;
        out_stall <= 1'b1;
      end else if (hold_cnt > 0) begin
        hold_cnt <= hold_cnt - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !quiet && ($urandom_range(99) < 37);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || psel) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, idle_cycles);
      $display("FAILURE");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic reg_write(logic [1:0] idx, logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      apc_pkg::REG_NODE_COUNT: cfg_nodes = val[6:0];
      apc_pkg::REG_ITERATION_COUNT: cfg_iters = val[9:0];
      apc_pkg::REG_DAMPING: cfg_damp = val[15:0];
      default: cfg_pref = val;
    endcase
  endtask

  task automatic drain();
    wait (pending_entries.size() == 0 && !in_valid && expected_assignments.size() == 0);
    repeat (20) @(posedge clk);
  endtask

  task automatic setup(logic [6:0] n, logic [9:0] it, logic [15:0] d, logic signed [31:0] p);
    drain();
    reg_write(apc_pkg::REG_NODE_COUNT, {25'd0, n});
    reg_write(apc_pkg::REG_ITERATION_COUNT, {22'd0, it});
    reg_write(apc_pkg::REG_DAMPING, {16'd0, d});
    reg_write(apc_pkg::REG_PREFERENCE, p);
  endtask

  task automatic queue_entry(logic signed [31:0] v, logic last);
    entry_t e;
    int n;
    n = active_count(cfg_nodes);
    if (gen_ptr < n*n) begin
      gen_written[(gen_ptr / n)*MAXN + gen_ptr % n] = 1'b1;
      gen_ptr++;
    end
    if (last) gen_ptr = 0;
    e.sim = v;
    e.last = last;
    pending_entries = {pending_entries, e};
  endtask

  function automatic logic signed [31:0] pick_similarity();
    int k;
    k = $urandom_range(99);
    if (k < 70) return -$signed({1'b0, $urandom_range(20 << 16)});
    if (k < 85) return $urandom;
    case ($urandom_range(3))
      0: return apc_pkg::S32_MIN;
      1: return apc_pkg::S32_MAX;
      2: return 32'sd0;
      default: return -32'sd1;
    endcase
  endfunction

  function automatic bit matrix_covered(int n);
    for (int r = 0; r < n; r++)
      for (int c = 0; c < n; c++)
        if (r != c && !gen_written[r*MAXN+c]) return 1'b0;
    return 1'b1;
  endfunction

  task automatic queue_matrix(int count);
    for (int k = 0; k < count; k++) queue_entry(pick_similarity(), k == count-1);
  endtask

  initial begin
    int n, mode, cnt, random_items;
    logic [6:0] nc;
    logic [9:0] it;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    setup(7'd0, 10'd0, 16'd0, apc_pkg::S32_MIN);
    queue_entry(apc_pkg::S32_MAX, 1'b0);
    queue_entry(apc_pkg::S32_MIN, 1'b0);
    queue_entry(32'sd0, 1'b0);
    queue_entry(-32'sd1, 1'b1);
    setup(7'd2, 10'd1023, 16'd65535, apc_pkg::S32_MAX);
    queue_entry(32'sh00010000, 1'b0);
    queue_entry(-32'sh00030000, 1'b0);
    queue_entry(apc_pkg::S32_MIN, 1'b0);
    queue_entry(apc_pkg::S32_MAX, 1'b1);
    setup(7'd3, 10'd20, 16'd32768, -32'sh00020000);
    for (int k = 0; k < 12; k++) queue_entry(-$signed(32'(k) << 16), k == 11);
    setup(7'd3, 10'd5, 16'd16384, 32'sh00008000);
    queue_entry(-32'sh00050000, 1'b0);
    queue_entry(-32'sh00010000, 1'b1);
    setup(7'd2, 10'd8, 16'd49152, -32'sh00010000);
    queue_entry(-32'sh00020000, 1'b0);
    queue_entry(-32'sh00040000, 1'b0);
    drain();
    reg_write(apc_pkg::REG_NODE_COUNT, 32'd3);
    for (int k = 0; k < 7; k++) queue_entry(pick_similarity(), k == 6);

    setup(7'd8, 10'd40, 16'd32768, -32'sh00100000);
    queue_matrix(64);

    random_items = 0;
    while (random_items < 335) begin
      nc = ($urandom_range(9) == 0) ? 7'($urandom_range(1)) : 7'($urandom_range(2, 6));
      n = active_count(nc);
      if (n <= 3) it = ($urandom_range(19) == 0) ? 10'd1023 : 10'($urandom_range(200));
      else it = 10'($urandom_range(1, 25));
      setup(nc, it, 16'($urandom), ($urandom_range(3) == 0) ? $urandom :
            -$signed({1'b0, $urandom_range(10 << 16)}));
      for (int g = 0; g < 3; g++) begin
        mode = $urandom_range(9);
        cnt = n*n;
        if (mode == 0) cnt = n*n + $urandom_range(1, 5);
        else if (mode == 1 && matrix_covered(n)) cnt = $urandom_range(1, n*n-1);
        queue_matrix(cnt);
        random_items += cnt;
      end
    end
    drain();
    repeat (200) @(posedge clk);
    $display("Covered %0d similarity requests over %0d clustering runs, %0d node results.",
             entries_taken, runs_done, results_seen);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
`default_nettype wire
